// ----- sv/cas_pkg.sv -----
// Shared types, constants and helpers for the cave smoothing core.
package cas_pkg;

	localparam int MAX_WIDTH_DEF = 128;
	localparam int MAX_HEIGHT    = 128;
	localparam int MIN_DIM       = 5;

	localparam int NEAR_W     = 4;
	localparam int FAR_W      = 6;
	localparam int DIM_W      = 8;
	localparam int ROW_W      = 8;
	localparam int CFG_DATA_W = 8;

	localparam int WIN_N    = 5;
	localparam int WIN_BITS = WIN_N * WIN_N;
	localparam int BANKS    = 4;
	localparam int BANK_W   = 2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(5);
	localparam logic [FAR_W-1:0]  FAR_RESET  = FAR_W'(2);
	localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(64);

	typedef enum logic [1:0] {
		CFG_NEAR_THRESHOLD = 2'd0,
		CFG_FAR_THRESHOLD  = 2'd1,
		CFG_FRAME_WIDTH    = 2'd2,
		CFG_FRAME_HEIGHT   = 2'd3
	} cfg_index_t;

	typedef enum logic {
		CMD_CELL  = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef struct packed {
		logic cmd;
		logic cell_is_wall;
	} in_item_t;

	typedef struct packed {
		logic new_is_wall;
		logic frame_end;
	} out_item_t;

	// One emitting item: masked 5x5 neighborhood plus position flags.
	typedef struct packed {
		logic [WIN_BITS-1:0] win;
		logic                border;
		logic                last;
	} work_t;

	typedef struct packed {
		logic s1_valid;
		logic push;
	} front_stat_t;

	// Row 0 is two rows above the cell, age 0 is two columns to its right.
	function automatic int win_idx(input int row, input int age);
		return row * WIN_N + age;
	endfunction

endpackage

// ----- sv/cave_automaton_smoothing_core.sv -----
// Top level of the cave smoothing core: configuration registers and block wiring.
// One smoothing generation over a wall map streamed in raster order, one item per
// clock when the result side keeps up. Each item does a single read-modify-write of
// the column memory (four row banks side by side, one word per column), which sets
// the rate at one item per cycle. A result belongs to the cell two rows and two
// cells before the item that releases it, so send 2*W+2 flush items after the last
// cell to drain a frame; the result for the last cell carries frame_end, and the
// item after it starts a new frame. Items pass the front stage register and queue
// before the result register. Border cells pass through. Write configuration only
// between frames; rows held from a previous frame are never used in the new one.
module cave_automaton_smoothing_core import cas_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  in_item_t              item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [NEAR_W-1:0]        near_threshold_q;
	logic signed [FAR_W-1:0]  far_threshold_q;
	logic [DIM_W-1:0]         frame_width_q, frame_height_q;

	work_t       push_data, head;
	front_stat_t stat;
	logic        q_full, q_head_valid, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_threshold_q <= NEAR_RESET;
			far_threshold_q  <= FAR_RESET;
			frame_width_q    <= DIM_RESET;
			frame_height_q   <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NEAR_THRESHOLD: near_threshold_q <= cfg_data[NEAR_W-1:0];
				CFG_FAR_THRESHOLD:  far_threshold_q  <= cfg_data[FAR_W-1:0];
				CFG_FRAME_WIDTH:    frame_width_q    <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT:   frame_height_q   <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	cas_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.q_full       (q_full),
		.push_data    (push_data),
		.stat         (stat)
	);

	cas_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (stat.push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (head)
	);

	cas_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (q_head_valid),
		.head           (head),
		.pop            (q_pop),
		.near_threshold (near_threshold_q),
		.far_threshold  (far_threshold_q),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result         (result)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.push |-> !q_full)
		else $error("window queue written while full");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> stat.s1_valid)
		else $error("input stalled with an empty front stage");

	a_back_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(q_head_valid && !result_valid) |=> result_valid)
		else $error("queued item not moved to an empty result register");

endmodule

// ----- sv/cas_front.sv -----
// Front end: input handshake, raster counters, column memory and sliding window.
module cas_front import cas_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  in_item_t         item,
	input  logic [DIM_W-1:0] frame_width,
	input  logic [DIM_W-1:0] frame_height,
	input  logic             q_full,
	output work_t            push_data,
	output front_stat_t      stat
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 2;
	localparam logic [CMP_W-1:0] MAXW = CMP_W'(MAX_WIDTH);
	localparam logic [CMP_W-1:0] MAXH = CMP_W'(MAX_HEIGHT);
	localparam logic [CMP_W-1:0] MIND = CMP_W'(MIN_DIM);

	logic [COL_W-1:0]    in_col_q, out_col_q;
	logic [ROW_W-1:0]    in_row_q, out_row_q;
	logic [CMP_W-1:0]    fw_e, fh_e, w_c, h_c, ic_e, oc_e, ir_e, or_e;
	logic                accept, advance, emit, last, in_wrap, out_wrap, border, new_bit;
	logic [WIN_BITS-1:0] mask, win_q, win_nxt;
	logic [WIN_N-1:0]    col_ok, row_ok, col;

	logic [BANKS-1:0]    row_mem [MAX_WIDTH];

	logic                s1_valid_q;
	logic [BANKS-1:0]    rd_s1;
	logic                new_bit_s1, emit_s1, border_s1, last_s1;
	logic [BANK_W-1:0]   bank_s1;
	logic [WIN_BITS-1:0] mask_s1;

	function automatic logic [ROW_W-1:0] sat_inc(input logic [ROW_W-1:0] v);
		return (v == {ROW_W{1'b1}}) ? v : v + ROW_W'(1);
	endfunction

	// Clamp geometry to the supported range.
	always_comb begin
		fw_e = CMP_W'(frame_width);
		fh_e = CMP_W'(frame_height);
		w_c  = fw_e;
		h_c  = fh_e;
		if (fw_e < MIND) begin
			w_c = MIND;
		end else if (fw_e > MAXW) begin
			w_c = MAXW;
		end
		if (fh_e < MIND) begin
			h_c = MIND;
		end else if (fh_e > MAXH) begin
			h_c = MAXH;
		end
	end

	assign ic_e = CMP_W'(in_col_q);
	assign oc_e = CMP_W'(out_col_q);
	assign ir_e = CMP_W'(in_row_q);
	assign or_e = CMP_W'(out_row_q);

	assign advance    = s1_valid_q && (!emit_s1 || !q_full);
	assign item_ready = !s1_valid_q || advance;
	assign accept     = item_valid && item_ready;
	assign new_bit    = (item.cmd == CMD_CELL) ? item.cell_is_wall : 1'b0;

	assign emit     = (ir_e > CMP_W'(2)) || ((ir_e == CMP_W'(2)) && (ic_e >= CMP_W'(2)));
	assign in_wrap  = (ic_e + CMP_W'(1)) >= w_c;
	assign out_wrap = (oc_e + CMP_W'(1)) >= w_c;
	assign last     = out_wrap && ((or_e + CMP_W'(1)) >= h_c);
	assign border   = (or_e < CMP_W'(1)) || (oc_e < CMP_W'(1)) ||
		((or_e + CMP_W'(1)) >= h_c) || out_wrap;

	// Mark window positions that fall inside the map for the output cell.
	always_comb begin
		for (int j = 0; j < WIN_N; j++) begin
			col_ok[j] = ((oc_e + CMP_W'(2)) >= CMP_W'(j)) &&
				((oc_e + CMP_W'(2)) < (w_c + CMP_W'(j)));
		end
		for (int i = 0; i < WIN_N; i++) begin
			row_ok[i] = ((or_e + CMP_W'(i)) >= CMP_W'(2)) &&
				((or_e + CMP_W'(i)) < (h_c + CMP_W'(2)));
		end
		for (int i = 0; i < WIN_N; i++) begin
			for (int j = 0; j < WIN_N; j++) begin
				mask[win_idx(i, j)] = row_ok[i] & col_ok[j];
			end
		end
	end

	// Column memory: one bit lane per row bank, old word read before write.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_mem[in_col_q][in_row_q[BANK_W-1:0]] <= new_bit;
			rd_s1 <= row_mem[in_col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_bit_s1 <= new_bit;
			bank_s1    <= in_row_q[BANK_W-1:0];
			emit_s1    <= emit;
			border_s1  <= border;
			last_s1    <= last;
			mask_s1    <= mask;
		end
	end

	// Column oldest row first: the bank being overwritten holds the row four back.
	always_comb begin
		for (int i = 0; i < BANKS; i++) begin
			col[i] = rd_s1[bank_s1 + BANK_W'(i)];
		end
		col[WIN_N-1] = new_bit_s1;
		for (int i = 0; i < WIN_N; i++) begin
			win_nxt[win_idx(i, 0)] = col[i];
			for (int j = 1; j < WIN_N; j++) begin
				win_nxt[win_idx(i, j)] = win_q[win_idx(i, j - 1)];
			end
		end
	end

	assign push_data.win    = win_nxt & mask_s1;
	assign push_data.border = border_s1;
	assign push_data.last   = last_s1;
	assign stat.s1_valid    = s1_valid_q;
	assign stat.push        = advance && emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			win_q      <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				win_q <= win_nxt;
			end
			if (accept) begin
				if (emit && last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					if (in_wrap) begin
						in_col_q <= '0;
						in_row_q <= sat_inc(in_row_q);
					end else begin
						in_col_q <= COL_W'(ic_e + CMP_W'(1));
					end
					if (emit) begin
						if (out_wrap) begin
							out_col_q <= '0;
							out_row_q <= sat_inc(out_row_q);
						end else begin
							out_col_q <= COL_W'(oc_e + CMP_W'(1));
						end
					end
				end
			end
		end
	end

endmodule

// ----- sv/cas_queue.sv -----
// Short queue of window snapshots between front and back.
module cas_queue import cas_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output work_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	work_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/cas_back.sv -----
// Back end: neighbor counts, threshold tests and the result register.
module cas_back import cas_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  work_t                    head,
	output logic                     pop,
	input  logic [NEAR_W-1:0]        near_threshold,
	input  logic signed [FAR_W-1:0]  far_threshold,
	output logic                     result_valid,
	input  logic                     result_ready,
	output out_item_t                result
);

	localparam int NCNT_W = $clog2(WIN_BITS + 1);

	logic [WIN_BITS-1:0] near_sel, far_sel;
	logic [NCNT_W-1:0]   near_cnt, far_cnt;
	logic                near_hit, far_hit, nw;
	logic                result_valid_q;
	out_item_t           result_q;

	// Inner 3x3, and the 5x5 without its corners.
	always_comb begin
		near_sel = '0;
		for (int i = 1; i < WIN_N - 1; i++) begin
			for (int j = 1; j < WIN_N - 1; j++) begin
				near_sel[win_idx(i, j)] = 1'b1;
			end
		end
		far_sel = '1;
		far_sel[win_idx(0, 0)]                 = 1'b0;
		far_sel[win_idx(0, WIN_N - 1)]         = 1'b0;
		far_sel[win_idx(WIN_N - 1, 0)]         = 1'b0;
		far_sel[win_idx(WIN_N - 1, WIN_N - 1)] = 1'b0;
	end

	assign near_cnt = NCNT_W'($countones(head.win & near_sel));
	assign far_cnt  = NCNT_W'($countones(head.win & far_sel));
	assign near_hit = near_cnt >= NCNT_W'(near_threshold);
	assign far_hit  = $signed({2'b00, far_cnt}) <=
		$signed({{(NCNT_W + 2 - FAR_W){far_threshold[FAR_W-1]}}, far_threshold});
	// Border cells keep their old value.
	assign nw = head.border ? head.win[win_idx(2, 2)] : (near_hit || far_hit);

	assign pop          = head_valid && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.new_is_wall <= nw;
			result_q.frame_end   <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

endmodule
